>>> rtl/bmte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte matrix transform engine: shared types and constants
// Matrix geometry, command modes, datapath command bundle and neighbour offsets.
// ----------------------------------------------------------------------------
package bmte_pkg;

	localparam int MAX_DIM = 64;
	localparam int IW      = 6;
	localparam int DW      = 7;
	localparam int AW      = 2 * IW;
	localparam int CELLS   = MAX_DIM * MAX_DIM;

	typedef enum logic [3:0] {
		M_SIZE      = 4'd0,
		M_WRITE     = 4'd1,
		M_READ      = 4'd2,
		M_SWAPCELL  = 4'd3,
		M_SWAPROW   = 4'd4,
		M_SWAPCOL   = 4'd5,
		M_SWAPDIAG  = 4'd6,
		M_REVROW    = 4'd7,
		M_REVCOL    = 4'd8,
		M_REVDIAG   = 4'd9,
		M_MIRRORV   = 4'd10,
		M_MIRRORH   = 4'd11,
		M_ROTATE    = 4'd12,
		M_SWAPNBR   = 4'd13,
		M_TRANSPOSE = 4'd14
	} mode_t;

	typedef enum logic [1:0] {
		WS_SWAP_A,
		WS_SWAP_B,
		WS_VALUE,
		WS_SCRATCH
	} wsrc_t;

	typedef struct packed {
		logic          rd;
		logic          wr;
		wsrc_t         src;
		logic          wr_scr;
		logic [AW-1:0] addr_a;
		logic [AW-1:0] addr_b;
		logic [7:0]    value;
	} dp_cmd_t;

	function automatic logic [IW-1:0] nbr_dr(input logic [2:0] k);
		logic [IW-1:0] r;
		case (k)
			3'd0, 3'd1, 3'd7: r = {IW{1'b1}};
			3'd3, 3'd4, 3'd5: r = IW'(1);
			default:          r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [IW-1:0] nbr_dc(input logic [2:0] k);
		logic [IW-1:0] r;
		case (k)
			3'd1, 3'd2, 3'd3: r = IW'(1);
			3'd5, 3'd6, 3'd7: r = {IW{1'b1}};
			default:          r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/bmte_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte matrix datapath
// Cell memory with two read ports and one write port, scratch memory for rotate.
// ----------------------------------------------------------------------------
module bmte_dp import bmte_pkg::*; (
	input  logic       clk,
	input  dp_cmd_t    cmd,
	output logic [7:0] rd_data
);

	logic [7:0]    cells_q   [CELLS];
	logic [7:0]    scratch_q [CELLS];
	logic [7:0]    rda_q;
	logic [7:0]    rdb_q;
	logic [7:0]    rds_q;
	logic [7:0]    wdata;
	logic [AW-1:0] waddr;

	always_comb begin
		case (cmd.src)
			WS_SWAP_A:  wdata = rdb_q;
			WS_SWAP_B:  wdata = rda_q;
			WS_VALUE:   wdata = cmd.value;
			WS_SCRATCH: wdata = rds_q;
			default:    wdata = rda_q;
		endcase
	end

	assign waddr = (cmd.src == WS_SWAP_B) ? cmd.addr_b : cmd.addr_a;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rda_q <= cells_q[cmd.addr_a];
			rdb_q <= cells_q[cmd.addr_b];
			rds_q <= scratch_q[cmd.addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			cells_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_scr) begin
			scratch_q[cmd.addr_b] <= rda_q;
		end
	end

	assign rd_data = rda_q;

endmodule

>>> rtl/bmte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte matrix controller
// Command decode and range checks, swap loop sequencer and result register.
// ----------------------------------------------------------------------------
module bmte_ctrl import bmte_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [3:0]    in_mode,
	input  logic [7:0]    in_row_a,
	input  logic [7:0]    in_col_a,
	input  logic [7:0]    in_row_b,
	input  logic [7:0]    in_col_b,
	input  logic [7:0]    in_diag,
	input  logic [7:0]    in_value,
	input  logic [DW-1:0] in_new_rows,
	input  logic [DW-1:0] in_new_cols,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_ok,
	output logic [7:0]    out_read_byte,
	output logic [DW-1:0] out_cur_rows,
	output logic [DW-1:0] out_cur_cols,
	output dp_cmd_t       cmd,
	input  logic [7:0]    rd_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_LOOP, ST_RD, ST_WA, ST_WB, ST_RW, ST_WV, ST_FETCH, ST_DONE
	} state_t;

	state_t        state_q;
	mode_t         mode_q;
	logic [7:0]    ra_q, ca_q, rb_q, cb_q, d_q, val_q;
	logic [DW-1:0] nr_q, nc_q, rows_q, cols_q;
	logic [DW-1:0] i_q, j_q, ilim_q, jlim_q;
	logic [IW-1:0] ad_q, r0_q, c0_q, er_q, ec_q;
	logic          pass_q, ok_q;
	logic [7:0]    rd_q;
	logic          out_valid_q, out_ok_q;
	logic [7:0]    out_rd_q;
	logic [DW-1:0] out_rows_q, out_cols_q;

	logic          ra_in, ca_in, rb_in, cb_in, va, vb;
	logic          int_a, int_b, near_x, near_y, square, ad_ok, size_ok;
	logic [7:0]    ad8;
	logic [DW-1:0] len7;
	logic [IW-1:0] r0, c0;
	logic signed [8:0] dx, dy;
	logic          dec_ok;
	logic [DW-1:0] dec_ilim, dec_jlim;
	logic [IW-1:0] ar, ac, br, bc, i6, j6, rm1, cm1;
	logic [2:0]    k;

	assign ra_in = !ra_q[7] && (ra_q[DW-1:0] < rows_q);
	assign rb_in = !rb_q[7] && (rb_q[DW-1:0] < rows_q);
	assign ca_in = !ca_q[7] && (ca_q[DW-1:0] < cols_q);
	assign cb_in = !cb_q[7] && (cb_q[DW-1:0] < cols_q);
	assign va    = ra_in && ca_in;
	assign vb    = rb_in && cb_in;

	assign int_a = !ra_q[7] && (ra_q != 8'd0) && (({1'b0, ra_q[6:0]} + 8'd1) < {1'b0, rows_q})
		&& !ca_q[7] && (ca_q != 8'd0) && (({1'b0, ca_q[6:0]} + 8'd1) < {1'b0, cols_q});
	assign int_b = !rb_q[7] && (rb_q != 8'd0) && (({1'b0, rb_q[6:0]} + 8'd1) < {1'b0, rows_q})
		&& !cb_q[7] && (cb_q != 8'd0) && (({1'b0, cb_q[6:0]} + 8'd1) < {1'b0, cols_q});
	assign dx     = $signed({ca_q[7], ca_q}) - $signed({cb_q[7], cb_q});
	assign dy     = $signed({ra_q[7], ra_q}) - $signed({rb_q[7], rb_q});
	assign near_x = (dx >= -9'sd2) && (dx <= 9'sd2);
	assign near_y = (dy >= -9'sd2) && (dy <= 9'sd2);

	assign square  = (rows_q == cols_q) && (rows_q != '0);
	assign ad8     = d_q[7] ? 8'(~d_q + 8'd1) : d_q;
	assign ad_ok   = ad8 < {1'b0, rows_q};
	assign len7    = rows_q - ad8[DW-1:0];
	assign r0      = d_q[7] ? ad8[IW-1:0] : '0;
	assign c0      = d_q[7] ? '0 : ad8[IW-1:0];
	assign size_ok = (nr_q <= DW'(MAX_DIM)) && (nc_q <= DW'(MAX_DIM));

	always_comb begin
		dec_ok   = 1'b0;
		dec_ilim = '0;
		dec_jlim = DW'(1);
		case (mode_q)
			M_SIZE:      dec_ok = size_ok;
			M_WRITE:     dec_ok = va;
			M_READ:      dec_ok = va;
			M_SWAPCELL: begin
				dec_ok   = va && vb;
				dec_ilim = DW'(1);
			end
			M_SWAPROW: begin
				dec_ok   = ra_in && rb_in;
				dec_ilim = cols_q;
			end
			M_SWAPCOL: begin
				dec_ok   = ca_in && cb_in;
				dec_ilim = rows_q;
			end
			M_SWAPDIAG: begin
				dec_ok   = square && ad_ok;
				dec_ilim = len7;
			end
			M_REVROW: begin
				dec_ok   = ra_in;
				dec_ilim = cols_q >> 1;
			end
			M_REVCOL: begin
				dec_ok   = ca_in;
				dec_ilim = rows_q >> 1;
			end
			M_REVDIAG: begin
				dec_ok   = square && ad_ok;
				dec_ilim = len7 >> 1;
			end
			M_MIRRORV: begin
				dec_ok   = 1'b1;
				dec_ilim = rows_q;
				dec_jlim = cols_q >> 1;
			end
			M_MIRRORH: begin
				dec_ok   = 1'b1;
				dec_ilim = rows_q >> 1;
				dec_jlim = cols_q;
			end
			M_ROTATE: begin
				dec_ok   = 1'b1;
				dec_ilim = rows_q;
				dec_jlim = cols_q;
			end
			M_SWAPNBR: begin
				dec_ok   = int_a && int_b && !(near_x && near_y);
				dec_ilim = DW'(8);
			end
			M_TRANSPOSE: begin
				dec_ok   = rows_q == cols_q;
				dec_ilim = rows_q;
				dec_jlim = rows_q;
			end
			default: dec_ok = 1'b0;
		endcase
	end

	assign i6  = i_q[IW-1:0];
	assign j6  = j_q[IW-1:0];
	assign k   = i_q[2:0];
	assign rm1 = IW'(rows_q - DW'(1));
	assign cm1 = IW'(cols_q - DW'(1));

	always_comb begin
		ar = ra_q[IW-1:0];
		ac = ca_q[IW-1:0];
		br = rb_q[IW-1:0];
		bc = cb_q[IW-1:0];
		case (mode_q)
			M_SWAPROW: begin
				ac = i6;
				bc = i6;
			end
			M_SWAPCOL: begin
				ar = i6;
				br = i6;
			end
			M_SWAPDIAG: begin
				ar = i6;
				ac = i6 + ad_q;
				br = i6 + ad_q;
				bc = i6;
			end
			M_REVROW: begin
				ac = i6;
				br = ra_q[IW-1:0];
				bc = cm1 - i6;
			end
			M_REVCOL: begin
				ar = i6;
				br = rm1 - i6;
				bc = ca_q[IW-1:0];
			end
			M_REVDIAG: begin
				ar = r0_q + i6;
				ac = c0_q + i6;
				br = er_q - i6;
				bc = ec_q - i6;
			end
			M_MIRRORV: begin
				ar = i6;
				ac = j6;
				br = i6;
				bc = cm1 - j6;
			end
			M_MIRRORH: begin
				ar = i6;
				ac = j6;
				br = rm1 - i6;
				bc = j6;
			end
			M_ROTATE: begin
				ar = i6;
				ac = j6;
				br = j6;
				bc = rm1 - i6;
			end
			M_SWAPNBR: begin
				ar = ra_q[IW-1:0] + nbr_dr(k);
				ac = ca_q[IW-1:0] + nbr_dc(k);
				br = rb_q[IW-1:0] + nbr_dr(k);
				bc = cb_q[IW-1:0] + nbr_dc(k);
			end
			M_TRANSPOSE: begin
				ar = i6;
				ac = j6;
				br = j6;
				bc = i6;
			end
			default: ar = ra_q[IW-1:0];
		endcase
	end

	always_comb begin
		cmd.rd     = state_q == ST_RD;
		cmd.wr     = (state_q == ST_WA) || (state_q == ST_WB) || (state_q == ST_WV)
			|| ((state_q == ST_RW) && pass_q);
		cmd.wr_scr = (state_q == ST_RW) && !pass_q;
		cmd.addr_a = {ar, ac};
		cmd.addr_b = {br, bc};
		cmd.value  = val_q;
		case (state_q)
			ST_WB:   cmd.src = WS_SWAP_B;
			ST_WV:   cmd.src = WS_VALUE;
			ST_RW:   cmd.src = WS_SCRATCH;
			default: cmd.src = WS_SWAP_A;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= '0;
			cols_q      <= '0;
			out_valid_q <= 1'b0;
			pass_q      <= 1'b0;
			ok_q        <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode_t'(in_mode);
						ra_q    <= in_row_a;
						ca_q    <= in_col_a;
						rb_q    <= in_row_b;
						cb_q    <= in_col_b;
						d_q     <= in_diag;
						val_q   <= in_value;
						nr_q    <= in_new_rows;
						nc_q    <= in_new_cols;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					ok_q   <= dec_ok;
					rd_q   <= 8'd0;
					ilim_q <= dec_ilim;
					jlim_q <= dec_jlim;
					i_q    <= '0;
					j_q    <= (mode_q == M_TRANSPOSE) ? DW'(1) : '0;
					pass_q <= 1'b0;
					ad_q   <= ad8[IW-1:0];
					r0_q   <= r0;
					c0_q   <= c0;
					er_q   <= r0 + len7[IW-1:0] - IW'(1);
					ec_q   <= c0 + len7[IW-1:0] - IW'(1);
					if (!dec_ok) begin
						state_q <= ST_DONE;
					end else begin
						case (mode_q)
							M_SIZE: begin
								if ((nr_q == '0) || (nc_q == '0)) begin
									rows_q <= '0;
									cols_q <= '0;
								end else begin
									rows_q <= nr_q;
									cols_q <= nc_q;
								end
								state_q <= ST_DONE;
							end
							M_WRITE: state_q <= ST_WV;
							M_READ:  state_q <= ST_RD;
							default: state_q <= ST_LOOP;
						endcase
					end
				end
				ST_LOOP: begin
					if (i_q >= ilim_q) begin
						if ((mode_q == M_ROTATE) && !pass_q) begin
							pass_q <= 1'b1;
							i_q    <= '0;
							j_q    <= '0;
							ilim_q <= cols_q;
							jlim_q <= rows_q;
						end else begin
							if (mode_q == M_ROTATE) begin
								rows_q <= cols_q;
								cols_q <= rows_q;
							end
							state_q <= ST_DONE;
						end
					end else if (j_q >= jlim_q) begin
						i_q <= i_q + DW'(1);
						j_q <= (mode_q == M_TRANSPOSE) ? i_q + DW'(2) : '0;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (mode_q == M_READ) begin
						state_q <= ST_FETCH;
					end else if (mode_q == M_ROTATE) begin
						state_q <= ST_RW;
					end else begin
						state_q <= ST_WA;
					end
				end
				ST_WA: state_q <= ST_WB;
				ST_WB: begin
					j_q     <= j_q + DW'(1);
					state_q <= ST_LOOP;
				end
				ST_RW: begin
					j_q     <= j_q + DW'(1);
					state_q <= ST_LOOP;
				end
				ST_WV: state_q <= ST_DONE;
				ST_FETCH: begin
					rd_q    <= rd_data;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= ok_q;
						out_rd_q    <= rd_q;
						out_rows_q  <= rows_q;
						out_cols_q  <= cols_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready      = state_q == ST_IDLE;
	assign out_valid     = out_valid_q;
	assign out_ok        = out_ok_q;
	assign out_read_byte = out_rd_q;
	assign out_cur_rows  = out_rows_q;
	assign out_cur_cols  = out_cols_q;

endmodule

>>> rtl/byte_matrix_transform_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte matrix transform engine
// Holds a byte matrix of up to 64 by 64 cells and runs one command per item.
// ----------------------------------------------------------------------------
// One command is taken at a time and answered with one result item.
// Every cell exchange is a read of both cells through the two read ports of
// the cell memory followed by two writes through its single write port; row,
// column, diagonal, mirror, neighbour and transpose commands exchange their
// pairs this way. Rotate copies every cell to the scratch memory and back.
// The next command is taken while a result still waits on the output.
module byte_matrix_transform_engine import bmte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// row_a[7:0], col_a[15:8], row_b[23:16], col_b[31:24], diag_offset[39:32],
	// cell_value[47:40], new_rows[54:48], new_cols[61:55], zero[63:62]
	input  logic [63:0] s_tdata,
	// mode[3:0]
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// ok[0], read_byte[8:1], cur_rows[15:9], cur_cols[22:16], zero[23]
	output logic [23:0] m_tdata
);

	dp_cmd_t       cmd;
	logic [7:0]    rd_data;
	logic          ok;
	logic [7:0]    read_byte;
	logic [DW-1:0] cur_rows, cur_cols;

	bmte_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_mode       (s_tuser),
		.in_row_a      (s_tdata[7:0]),
		.in_col_a      (s_tdata[15:8]),
		.in_row_b      (s_tdata[23:16]),
		.in_col_b      (s_tdata[31:24]),
		.in_diag       (s_tdata[39:32]),
		.in_value      (s_tdata[47:40]),
		.in_new_rows   (s_tdata[54:48]),
		.in_new_cols   (s_tdata[61:55]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_ok        (ok),
		.out_read_byte (read_byte),
		.out_cur_rows  (cur_rows),
		.out_cur_cols  (cur_cols),
		.cmd           (cmd),
		.rd_data       (rd_data)
	);

	bmte_dp u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.rd_data (rd_data)
	);

	assign m_tdata = {1'b0, cur_cols, cur_rows, read_byte, ok};

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while a command is in progress");

	a_dims_paired: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[15:9] == 7'd0) == (m_tdata[22:16] == 7'd0)))
		else $error("one dimension zero without the other");

	a_dims_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:9] <= 7'(MAX_DIM)) && (m_tdata[22:16] <= 7'(MAX_DIM)))
		else $error("dimension above limit");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
		else $error("failed command returned read data");

endmodule
